### rtl/core/psls_pkg.sv
// shared types and constants for the per-source latency statistics block
`timescale 1ns / 1ps

package psls_pkg;

    // table geometry
    localparam int MAX_SOURCES = 16;
    localparam int SRC_W       = $clog2(MAX_SOURCES);
    localparam int CFG_W       = 5;

    // record field widths
    localparam int CNT_W  = 32;
    localparam int DLY_W  = 24;
    localparam int TOT_W  = 56;
    localparam int STEP_W = $clog2(DLY_W);

    // saturation limits
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
    localparam logic [DLY_W-1:0] DLY_MAX = {DLY_W{1'b1}};
    localparam logic [TOT_W-1:0] TOT_MAX = {TOT_W{1'b1}};

    // reset value of the active source count
    localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(MAX_SOURCES);

    // request type codes
    localparam logic REQ_PRODUCED = 1'b0;
    localparam logic REQ_CONSUMED = 1'b1;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_UPDATE,
        S_DIVIDE,
        S_REPORT
    } t_state;

endpackage

### rtl/core/per_source_latency_stats_core.sv
// per-source latency statistics: counters, min, max and average delay per source
`timescale 1ns / 1ps

// Keeps one record per source (produced and consumed counts, min, max, total
// and average delay) and returns the updated record for every request. A
// request passes through the update and report states for a produced event,
// a first sample, a bad index or a saturated average; its result is loaded in
// the report state. When the average has to be recomputed, the divide state
// comes between them: one shared restoring divider produces one of the 24
// quotient bits per cycle. The input side is not ready while a request is
// being worked on. The result sits in an output register, so the next
// request can be taken while it waits; a result that is still not taken
// holds that next request in its last cycle. Writing active_sources does not
// clear the tables; only reset does.
module per_source_latency_stats_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [psls_pkg::CFG_W-1:0]  i_cfg_wdata,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_req_type,
    input  logic [psls_pkg::SRC_W-1:0]  i_source_index,
    input  logic [psls_pkg::DLY_W-1:0]  i_delay_us,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_bad_index,
    output logic [psls_pkg::SRC_W-1:0]  o_source_out,
    output logic [psls_pkg::CNT_W-1:0]  o_produced_count,
    output logic [psls_pkg::CNT_W-1:0]  o_consumed_count,
    output logic                        o_has_sample,
    output logic [psls_pkg::DLY_W-1:0]  o_min_delay_us,
    output logic [psls_pkg::DLY_W-1:0]  o_max_delay_us,
    output logic [psls_pkg::DLY_W-1:0]  o_avg_delay_us
);
    import psls_pkg::*;

    // sequencer and request registers
    t_state             r_state, n_state;
    logic               r_type;
    logic [SRC_W-1:0]   r_src;
    logic [DLY_W-1:0]   r_delay;
    logic               r_bad, n_bad;
    logic [CFG_W-1:0]   r_active;

    // statistics tables
    logic [CNT_W-1:0]   r_prod_tab [MAX_SOURCES];
    logic [CNT_W-1:0]   r_cons_tab [MAX_SOURCES];
    logic               r_seen_tab [MAX_SOURCES];
    logic [DLY_W-1:0]   r_min_tab  [MAX_SOURCES];
    logic [DLY_W-1:0]   r_max_tab  [MAX_SOURCES];
    logic [TOT_W-1:0]   r_tot_tab  [MAX_SOURCES];
    logic [DLY_W-1:0]   r_avg_tab  [MAX_SOURCES];

    // divider registers
    logic [CNT_W-1:0]   r_rem,  n_rem;
    logic [DLY_W-1:0]   r_quo,  n_quo;
    logic [STEP_W-1:0]  r_step, n_step;

    // output register
    logic               r_out_valid, n_out_valid;
    logic               w_out_load;

    // entry write enables and values
    logic               w_prod_we, w_cons_we, w_stat_we, w_avg_we;
    logic [CNT_W-1:0]   n_prod, n_cons;
    logic [DLY_W-1:0]   n_min, n_max, n_avg;
    logic [TOT_W-1:0]   n_tot;

    // current entry and update arithmetic
    logic [CNT_W-1:0]   cur_prod, cur_cons;
    logic               cur_seen;
    logic [DLY_W-1:0]   cur_min, cur_max;
    logic [TOT_W-1:0]   cur_tot;
    logic [CNT_W-1:0]   prod_inc, cons_inc;
    logic [TOT_W:0]     tot_sum;
    logic [TOT_W-1:0]   tot_new;
    logic [CNT_W+1:0]   div_diff;
    logic               div_ge;

    // output payload registers
    logic               r_o_bad;
    logic [SRC_W-1:0]   r_o_src;
    logic [CNT_W-1:0]   r_o_prod, r_o_cons;
    logic               r_o_seen;
    logic [DLY_W-1:0]   r_o_min, r_o_max, r_o_avg;

    // read of the addressed entry
    always_comb begin
        cur_prod = r_prod_tab[r_src];
        cur_cons = r_cons_tab[r_src];
        cur_seen = r_seen_tab[r_src];
        cur_min  = r_min_tab[r_src];
        cur_max  = r_max_tab[r_src];
        cur_tot  = r_tot_tab[r_src];
    end

    // saturating increments and total update
    always_comb begin
        prod_inc = (cur_prod == CNT_MAX) ? cur_prod : cur_prod + CNT_W'(1);
        cons_inc = (cur_cons == CNT_MAX) ? cur_cons : cur_cons + CNT_W'(1);
        tot_sum  = {1'b0, cur_tot} + (TOT_W+1)'(r_delay);
        tot_new  = tot_sum[TOT_W] ? TOT_MAX : tot_sum[TOT_W-1:0];
    end

    // one restoring divider step, divisor is the stored consumed count
    always_comb begin
        div_diff = {1'b0, r_rem, r_quo[DLY_W-1]} - {2'b00, cur_cons};
        div_ge   = !div_diff[CNT_W+1];
    end

    // sequencer next state and table write controls
    always_comb begin
        n_state     = r_state;
        n_bad       = r_bad;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        w_out_load  = 1'b0;
        w_prod_we   = 1'b0;
        w_cons_we   = 1'b0;
        w_stat_we   = 1'b0;
        w_avg_we    = 1'b0;
        n_prod      = prod_inc;
        n_cons      = cons_inc;
        n_min       = cur_min;
        n_max       = cur_max;
        n_tot       = tot_new;
        n_avg       = n_quo;

        // result taken downstream
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_bad   = ({1'b0, r_src} >= r_active);
                n_state = S_REPORT;
                if (!n_bad) begin
                    if (r_type == REQ_PRODUCED) begin
                        w_prod_we = 1'b1;
                    end else begin
                        w_cons_we = 1'b1;
                        w_stat_we = 1'b1;
                        w_avg_we  = 1'b1;
                        if (!cur_seen) begin
                            // first sample seeds every statistic
                            n_min = r_delay;
                            n_max = r_delay;
                            n_tot = TOT_W'(r_delay);
                            n_avg = r_delay;
                        end else begin
                            n_min = (r_delay < cur_min) ? r_delay : cur_min;
                            n_max = (r_delay > cur_max) ? r_delay : cur_max;
                            priority if (cons_inc == '0) begin
                                n_avg = '0;
                            end else if (tot_new[TOT_W-1:DLY_W] >= cons_inc) begin
                                // quotient would not fit in the average field
                                n_avg = DLY_MAX;
                            end else begin
                                // leave the average to the divider
                                w_avg_we = 1'b0;
                                n_rem    = tot_new[TOT_W-1:DLY_W];
                                n_quo    = tot_new[DLY_W-1:0];
                                n_step   = '0;
                                n_state  = S_DIVIDE;
                            end
                        end
                    end
                end
            end
            S_DIVIDE: begin
                n_rem  = div_ge ? div_diff[CNT_W-1:0] : {r_rem[CNT_W-2:0], r_quo[DLY_W-1]};
                n_quo  = {r_quo[DLY_W-2:0], div_ge};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DLY_W - 1)) begin
                    w_avg_we = 1'b1;
                    n_avg    = n_quo;
                    n_state  = S_REPORT;
                end
            end
            S_REPORT: begin
                if (!r_out_valid || i_out_ready) begin
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state, control and table registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_active    <= ACTIVE_RESET;
            for (int k = 0; k < MAX_SOURCES; k++) begin
                r_prod_tab[k] <= '0;
                r_cons_tab[k] <= '0;
                r_seen_tab[k] <= 1'b0;
                r_min_tab[k]  <= '0;
                r_max_tab[k]  <= '0;
                r_tot_tab[k]  <= '0;
                r_avg_tab[k]  <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (w_prod_we) begin
                r_prod_tab[r_src] <= n_prod;
            end
            if (w_cons_we) begin
                r_cons_tab[r_src] <= n_cons;
            end
            if (w_stat_we) begin
                r_seen_tab[r_src] <= 1'b1;
                r_min_tab[r_src]  <= n_min;
                r_max_tab[r_src]  <= n_max;
                r_tot_tab[r_src]  <= n_tot;
            end
            if (w_avg_we) begin
                r_avg_tab[r_src] <= n_avg;
            end
        end
    end

    // request capture, divider and result payload
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_type  <= i_req_type;
            r_src   <= i_source_index;
            r_delay <= i_delay_us;
        end
        r_bad  <= n_bad;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_step <= n_step;
        if (w_out_load) begin
            r_o_bad <= r_bad;
            r_o_src <= r_src;
            if (r_bad) begin
                r_o_prod <= '0;
                r_o_cons <= '0;
                r_o_seen <= 1'b0;
                r_o_min  <= '0;
                r_o_max  <= '0;
                r_o_avg  <= '0;
            end else begin
                r_o_prod <= cur_prod;
                r_o_cons <= cur_cons;
                r_o_seen <= cur_seen;
                r_o_min  <= cur_min;
                r_o_max  <= cur_max;
                r_o_avg  <= r_avg_tab[r_src];
            end
        end
    end

    // ports
    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_bad_index      = r_o_bad;
    assign o_source_out     = r_o_src;
    assign o_produced_count = r_o_prod;
    assign o_consumed_count = r_o_cons;
    assign o_has_sample     = r_o_seen;
    assign o_min_delay_us   = r_o_min;
    assign o_max_delay_us   = r_o_max;
    assign o_avg_delay_us   = r_o_avg;

endmodule

### rtl/core/psls_checker.sv
// port-level checks for the per-source latency statistics block and their binding
`timescale 1ns / 1ps

module psls_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_ready,
    input  logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic                        o_bad_index,
    input  logic [psls_pkg::CNT_W-1:0]  o_produced_count,
    input  logic [psls_pkg::CNT_W-1:0]  o_consumed_count,
    input  logic                        o_has_sample,
    input  logic [psls_pkg::DLY_W-1:0]  o_min_delay_us,
    input  logic [psls_pkg::DLY_W-1:0]  o_max_delay_us,
    input  logic [psls_pkg::DLY_W-1:0]  o_avg_delay_us
);
    import psls_pkg::*;

    // a pending result is held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped before it was taken");

    // one request at a time: ready falls after each acceptance
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second request taken while busy");

    // a bad index reports an empty record
    a_bad_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_bad_index |-> o_produced_count == '0 &&
            o_consumed_count == '0 && !o_has_sample && o_avg_delay_us == '0)
        else $error("bad index with non-empty record");

    // no sample means no consumed items and zero statistics
    a_no_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_sample |-> o_consumed_count == '0 &&
            o_min_delay_us == '0 && o_max_delay_us == '0 && o_avg_delay_us == '0)
        else $error("statistics without a sample");

    // min never exceeds max
    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_has_sample |-> o_min_delay_us <= o_max_delay_us)
        else $error("minimum delay above maximum");

endmodule

bind per_source_latency_stats_core psls_checker u_psls_checker (.*);

### sim/tb.sv
// self-checking testbench for the per-source latency statistics core
`timescale 1ns / 1ps

module tb;
    import psls_pkg::*;

    // one reported record, as the result port presents it
    typedef struct packed {
        logic             bad;
        logic [SRC_W-1:0] source;
        logic [CNT_W-1:0] produced;
        logic [CNT_W-1:0] consumed;
        logic             has_sample;
        logic [DLY_W-1:0] min_dly;
        logic [DLY_W-1:0] max_dly;
        logic [DLY_W-1:0] avg_dly;
    } t_stat_rec;

    // directed table: a request or a write of active_sources
    typedef enum logic {
        ROW_REQ,
        ROW_CFG
    } t_row_op;

    typedef struct packed {
        t_row_op          op;
        logic             req_type;
        logic [SRC_W-1:0] source;
        logic [DLY_W-1:0] delay;
        logic [CFG_W-1:0] setting;
        logic             typed;
        t_stat_rec        want;
    } t_stim_row;

    localparam int        PERIOD_HALF  = 2;
    localparam int        RESET_CYCLES = 8;
    localparam int        SETTLE       = 30;
    localparam int        HOLD_CYCLES  = 300;
    localparam int        TAIL_CYCLES  = 40;
    localparam int        TIMEOUT_NS   = 2_000_000;
    localparam int        PHASES       = 9;
    localparam int        PHASE_ITEMS  = 235;
    localparam int        DIR_ROWS     = 24;
    localparam t_stat_rec NO_REC       = '0;

    localparam t_stim_row DIR_TABLE [DIR_ROWS] = '{
        // reset state, extremes of the delay, first and later samples
        '{ROW_REQ, REQ_PRODUCED, 4'd0,  24'hFFFFFF, 5'd0, 1'b1,
          '{1'b0, 4'd0, 32'd1, 32'd0, 1'b0, 24'd0, 24'd0, 24'd0}},
        '{ROW_REQ, REQ_CONSUMED, 4'd0,  24'h000000, 5'd0, 1'b1,
          '{1'b0, 4'd0, 32'd1, 32'd1, 1'b1, 24'd0, 24'd0, 24'd0}},
        '{ROW_REQ, REQ_CONSUMED, 4'd0,  24'hFFFFFF, 5'd0, 1'b1,
          '{1'b0, 4'd0, 32'd1, 32'd2, 1'b1, 24'd0, 24'hFFFFFF, 24'h7FFFFF}},
        '{ROW_REQ, REQ_CONSUMED, 4'd15, 24'hFFFFFF, 5'd0, 1'b1,
          '{1'b0, 4'd15, 32'd0, 32'd1, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}},
        '{ROW_REQ, REQ_CONSUMED, 4'd15, 24'h000001, 5'd0, 1'b1,
          '{1'b0, 4'd15, 32'd0, 32'd2, 1'b1, 24'd1, 24'hFFFFFF, 24'h800000}},
        '{ROW_REQ, REQ_PRODUCED, 4'd15, 24'h000000, 5'd0, 1'b1,
          '{1'b0, 4'd15, 32'd1, 32'd2, 1'b1, 24'd1, 24'hFFFFFF, 24'h800000}},
        // one tracked source: the boundary index is untracked
        '{ROW_CFG, REQ_PRODUCED, 4'd0,  24'd0,      5'd1, 1'b0, NO_REC},
        '{ROW_REQ, REQ_PRODUCED, 4'd1,  24'h000000, 5'd0, 1'b1,
          '{1'b1, 4'd1, 32'd0, 32'd0, 1'b0, 24'd0, 24'd0, 24'd0}},
        '{ROW_REQ, REQ_CONSUMED, 4'd15, 24'h123456, 5'd0, 1'b1,
          '{1'b1, 4'd15, 32'd0, 32'd0, 1'b0, 24'd0, 24'd0, 24'd0}},
        '{ROW_REQ, REQ_PRODUCED, 4'd0,  24'h000000, 5'd0, 1'b1,
          '{1'b0, 4'd0, 32'd2, 32'd2, 1'b1, 24'd0, 24'hFFFFFF, 24'h7FFFFF}},
        // no source tracked
        '{ROW_CFG, REQ_PRODUCED, 4'd0,  24'd0,      5'd0, 1'b0, NO_REC},
        '{ROW_REQ, REQ_CONSUMED, 4'd0,  24'h000005, 5'd0, 1'b1,
          '{1'b1, 4'd0, 32'd0, 32'd0, 1'b0, 24'd0, 24'd0, 24'd0}},
        // settings above the table size act as the full table
        '{ROW_CFG, REQ_PRODUCED, 4'd0,  24'd0,      5'd31, 1'b0, NO_REC},
        '{ROW_REQ, REQ_CONSUMED, 4'd15, 24'hAAAAAA, 5'd0, 1'b0, NO_REC},
        '{ROW_REQ, REQ_CONSUMED, 4'd14, 24'hFFFFFF, 5'd0, 1'b0, NO_REC},
        '{ROW_CFG, REQ_PRODUCED, 4'd0,  24'd0,      5'd17, 1'b0, NO_REC},
        '{ROW_REQ, REQ_PRODUCED, 4'd15, 24'h000000, 5'd0, 1'b0, NO_REC},
        '{ROW_REQ, REQ_CONSUMED, 4'd7,  24'h555555, 5'd0, 1'b1,
          '{1'b0, 4'd7, 32'd0, 32'd1, 1'b1, 24'h555555, 24'h555555, 24'h555555}},
        '{ROW_REQ, REQ_CONSUMED, 4'd7,  24'h000001, 5'd0, 1'b0, NO_REC},
        '{ROW_REQ, REQ_CONSUMED, 4'd7,  24'hFFFFFE, 5'd0, 1'b0, NO_REC},
        '{ROW_CFG, REQ_PRODUCED, 4'd0,  24'd0,      5'd16, 1'b0, NO_REC},
        '{ROW_REQ, REQ_CONSUMED, 4'd8,  24'h123456, 5'd0, 1'b0, NO_REC},
        '{ROW_REQ, REQ_PRODUCED, 4'd8,  24'h000000, 5'd0, 1'b0, NO_REC},
        '{ROW_REQ, REQ_CONSUMED, 4'd0,  24'h000007, 5'd0, 1'b0, NO_REC}
    };

    // clock, reset and block ports
    logic             i_clk          = 1'b0;
    logic             i_rst_n        = 1'b0;
    logic             i_cfg_we       = 1'b0;
    logic [CFG_W-1:0] i_cfg_wdata    = '0;
    logic             i_in_valid     = 1'b0;
    logic             o_in_ready;
    logic             i_req_type     = REQ_PRODUCED;
    logic [SRC_W-1:0] i_source_index = '0;
    logic [DLY_W-1:0] i_delay_us     = '0;
    logic             o_out_valid;
    logic             i_out_ready    = 1'b0;
    logic             o_bad_index;
    logic [SRC_W-1:0] o_source_out;
    logic [CNT_W-1:0] o_produced_count;
    logic [CNT_W-1:0] o_consumed_count;
    logic             o_has_sample;
    logic [DLY_W-1:0] o_min_delay_us;
    logic [DLY_W-1:0] o_max_delay_us;
    logic [DLY_W-1:0] o_avg_delay_us;

    // typed expectation travelling with the request on offer
    logic             row_typed = 1'b0;
    t_stat_rec        row_want  = '0;

    // shared run control
    bit               idle_on  = 1'b1;
    bit               hold_req = 1'b0;

    // per-source statistics as the block should hold them
    logic [CFG_W-1:0] active_cfg;
    logic [CNT_W-1:0] produced_tab [MAX_SOURCES];
    logic [CNT_W-1:0] consumed_tab [MAX_SOURCES];
    logic             seen_tab     [MAX_SOURCES];
    logic [DLY_W-1:0] min_tab      [MAX_SOURCES];
    logic [DLY_W-1:0] max_tab      [MAX_SOURCES];
    logic [TOT_W-1:0] total_tab    [MAX_SOURCES];
    logic [DLY_W-1:0] avg_tab      [MAX_SOURCES];

    t_stat_rec        pending_records [$];

    int unsigned      err_count   = 0;
    int unsigned      n_requests  = 0;
    int unsigned      n_produced  = 0;
    int unsigned      n_consumed  = 0;
    int unsigned      n_untracked = 0;
    int unsigned      n_results   = 0;
    int unsigned      cfg_writes  = 0;

    per_source_latency_stats_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_source_index   (i_source_index),
        .i_delay_us       (i_delay_us),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_bad_index      (o_bad_index),
        .o_source_out     (o_source_out),
        .o_produced_count (o_produced_count),
        .o_consumed_count (o_consumed_count),
        .o_has_sample     (o_has_sample),
        .o_min_delay_us   (o_min_delay_us),
        .o_max_delay_us   (o_max_delay_us),
        .o_avg_delay_us   (o_avg_delay_us)
    );

    // clock
    always begin
        #PERIOD_HALF i_clk = 1'b1;
        #PERIOD_HALF i_clk = 1'b0;
    end

    // update one source record for an accepted request and return what it reports
    function automatic t_stat_rec update_source_record(input logic kind,
                                                       input logic [SRC_W-1:0] src,
                                                       input logic [DLY_W-1:0] dly);
        t_stat_rec        rec;
        logic [TOT_W-1:0] quot;
        rec        = '0;
        rec.source = src;
        if ({1'b0, src} >= active_cfg) begin
            rec.bad = 1'b1;
        end else begin
            if (kind == REQ_PRODUCED) begin
                if (produced_tab[src] != CNT_MAX) produced_tab[src] = produced_tab[src] + 1;
            end else begin
                if (consumed_tab[src] != CNT_MAX) consumed_tab[src] = consumed_tab[src] + 1;
                if (!seen_tab[src]) begin
                    // first sample sets the whole delay record
                    seen_tab[src]  = 1'b1;
                    min_tab[src]   = dly;
                    max_tab[src]   = dly;
                    total_tab[src] = TOT_W'(dly);
                    avg_tab[src]   = dly;
                end else begin
                    if (dly < min_tab[src]) min_tab[src] = dly;
                    if (dly > max_tab[src]) max_tab[src] = dly;
                    // total sticks at its ceiling
                    if (total_tab[src] > TOT_MAX - TOT_W'(dly))
                        total_tab[src] = TOT_MAX;
                    else
                        total_tab[src] = total_tab[src] + TOT_W'(dly);
                    if (consumed_tab[src] == '0) begin
                        avg_tab[src] = '0;
                    end else begin
                        quot         = total_tab[src] / TOT_W'(consumed_tab[src]);
                        avg_tab[src] = (quot > TOT_W'(DLY_MAX)) ? DLY_MAX : quot[DLY_W-1:0];
                    end
                end
            end
            rec.produced   = produced_tab[src];
            rec.consumed   = consumed_tab[src];
            rec.has_sample = seen_tab[src];
            rec.min_dly    = min_tab[src];
            rec.max_dly    = max_tab[src];
            rec.avg_dly    = avg_tab[src];
        end
        return rec;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        if (got !== want) begin
            err_count++;
            $display("%0t ns: result %0d %s got 0x%0h want 0x%0h",
                     $time, n_results, field, got, want);
        end
    endtask

    // predictor, scoreboard and result check
    always @(posedge i_clk) begin : result_check
        t_stat_rec got;
        t_stat_rec want;
        if (!i_rst_n) begin
            active_cfg = ACTIVE_RESET;
            for (int i = 0; i < MAX_SOURCES; i++) begin
                produced_tab[i] = '0;
                consumed_tab[i] = '0;
                seen_tab[i]     = 1'b0;
                min_tab[i]      = '0;
                max_tab[i]      = '0;
                total_tab[i]    = '0;
                avg_tab[i]      = '0;
            end
        end else begin
            if (i_cfg_we) begin
                active_cfg = i_cfg_wdata;
                cfg_writes++;
            end
            // results first, so a stray result never meets a request of this edge
            if (o_out_valid && i_out_ready) begin
                got = '{o_bad_index, o_source_out, o_produced_count, o_consumed_count,
                        o_has_sample, o_min_delay_us, o_max_delay_us, o_avg_delay_us};
                if (pending_records.size() == 0) begin
                    err_count++;
                    $display("%0t ns: result with no request outstanding", $time);
                end else begin
                    want = pending_records.pop_front();
                    report_mismatch("bad_index",      64'(got.bad),      64'(want.bad));
                    report_mismatch("source_out",     64'(got.source),   64'(want.source));
                    report_mismatch("produced_count", 64'(got.produced), 64'(want.produced));
                    report_mismatch("consumed_count", 64'(got.consumed), 64'(want.consumed));
                    report_mismatch("has_sample",     64'(got.has_sample),
                                    64'(want.has_sample));
                    report_mismatch("min_delay_us",   64'(got.min_dly),  64'(want.min_dly));
                    report_mismatch("max_delay_us",   64'(got.max_dly),  64'(want.max_dly));
                    report_mismatch("avg_delay_us",   64'(got.avg_dly),  64'(want.avg_dly));
                end
                n_results++;
            end
            if (i_in_valid && o_in_ready) begin
                want = update_source_record(i_req_type, i_source_index, i_delay_us);
                n_requests++;
                if (want.bad) n_untracked++;
                else if (i_req_type == REQ_PRODUCED) n_produced++;
                else n_consumed++;
                pending_records.push_back(row_typed ? row_want : want);
            end
        end
    end

    // offer one request, after a random gap when gaps are on, and wait for it to be taken
    task automatic send_request(input logic kind, input logic [SRC_W-1:0] src,
                                input logic [DLY_W-1:0] dly, input logic typed,
                                input t_stat_rec want);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_req_type     <= kind;
        i_source_index <= src;
        i_delay_us     <= dly;
        row_typed      <= typed;
        row_want       <= want;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // write active_sources once the block has drained
    task automatic write_active(input logic [CFG_W-1:0] setting);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_records.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= setting;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // request side: reset, directed table, then random phases
    initial begin : request_side
        logic             kind;
        logic [SRC_W-1:0] src;
        logic [DLY_W-1:0] dly;
        logic [CFG_W-1:0] setting;
        int unsigned      eff;
        int unsigned      items;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TABLE[r].op == ROW_CFG)
                write_active(DIR_TABLE[r].setting);
            else
                send_request(DIR_TABLE[r].req_type, DIR_TABLE[r].source, DIR_TABLE[r].delay,
                             DIR_TABLE[r].typed, DIR_TABLE[r].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       setting = 5'd16;
                1:       setting = 5'd1;
                2:       setting = 5'd31;
                3:       setting = 5'd0;
                default: setting = CFG_W'($urandom_range(2, 15));
            endcase
            write_active(setting);
            eff     = (setting > MAX_SOURCES) ? MAX_SOURCES : setting;
            items   = (setting == 0) ? 40 : PHASE_ITEMS;
            idle_on = (p % 3) != 2;
            // long receiver hold-off so the block backs up into the request side
            if (p == 4) begin
                idle_on  = 1'b0;
                hold_req = 1'b1;
            end
            for (int k = 0; k < items; k++) begin
                kind = ($urandom_range(0, 2) != 0) ? REQ_CONSUMED : REQ_PRODUCED;
                if (eff == 0 || $urandom_range(0, 9) == 0)
                    src = SRC_W'($urandom_range(0, MAX_SOURCES - 1));
                else
                    src = SRC_W'($urandom_range(0, eff - 1));
                case ($urandom_range(0, 7))
                    0:       dly = '0;
                    1:       dly = DLY_MAX;
                    2:       dly = DLY_W'($urandom_range(0, 255));
                    3:       dly = DLY_MAX - DLY_W'($urandom_range(0, 255));
                    default: dly = DLY_W'($urandom);
                endcase
                send_request(kind, src, dly, 1'b0, NO_REC);
            end
        end

        // drain and let the block settle
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_records.size() != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d requests: %0d produced, %0d consumed, %0d on untracked sources",
                 n_requests, n_produced, n_consumed, n_untracked);
        $display("%0d results checked across %0d writes of active_sources, %0d mismatches",
                 n_results, cfg_writes, err_count);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // result side: random stalls, one long hold-off on request
    initial begin : result_side
        int unsigned stall;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                stall = idle_on ? $urandom_range(0, 7) : 0;
                if (stall != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    // watchdog
    initial begin : watchdog
        #TIMEOUT_NS;
        $display("run timed out with %0d results outstanding", pending_records.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
